>>> hw/rtl/prts_pkg.sv
// Shared types and codes for the priority ready table scheduler.
`default_nettype none

package prts_pkg;

   localparam logic [2:0] ACT_CREATE  = 3'd0;
   localparam logic [2:0] ACT_POST    = 3'd1;
   localparam logic [2:0] ACT_SUSPEND = 3'd2;
   localparam logic [2:0] ACT_DELAY   = 3'd3;
   localparam logic [2:0] ACT_TICK    = 3'd4;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } prts_state_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [2:0]  task_index;
      logic [15:0] delay_ticks;
   } prts_req_type;

   typedef struct packed {
      logic [2:0] task_now;
      logic       switched;
      logic [7:0] ready_bits;
   } prts_rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } prts_cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/prts_ctrl.sv
// Controller state machine: handshakes and sequencing of the datapath.
`default_nettype none

module prts_ctrl
   import prts_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output prts_cmd_type cmd
);

   prts_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            // The result register is free or drains at this edge.
            req_stall   = rsp_valid_ff && rsp_stall;
            cmd.capture = req_valid && !(rsp_valid_ff && rsp_stall);
         end
         ST_EXEC: begin
            cmd.execute  = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/prts_dpath.sv
// Datapath: ready bitmap, running level, wait counters and result register.
`default_nettype none

module prts_dpath
   import prts_pkg::*;
#(
   parameter int NUM_LEVELS = 8,
   parameter int TICK_BITS  = 16
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire prts_cmd_type  cmd,
   input  wire prts_req_type  req_data,
   output prts_rsp_type       rsp_data
);

   localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int PW = (LW > 3) ? LW : 3;
   localparam int MW = (NUM_LEVELS > 8) ? NUM_LEVELS : 8;
   localparam logic [LW-1:0] IDLE_LEVEL = LW'(NUM_LEVELS - 1);
   localparam logic [NUM_LEVELS-1:0] IDLE_MASK = {1'b1, {(NUM_LEVELS-1){1'b0}}};

   prts_req_type                 in_ff;
   prts_rsp_type                 rsp_ff, rsp_in;
   logic [NUM_LEVELS-1:0]        mask_ff, mask_in;
   logic [LW-1:0]                run_ff, run_in;
   logic [TICK_BITS-1:0]         wait_ff [NUM_LEVELS];
   logic [TICK_BITS-1:0]         wait_in [NUM_LEVELS];
   logic                         idx_ok;
   logic [LW-1:0]                idx_lvl;
   logic [TICK_BITS-1:0]         ticks;
   logic [PW-1:0]                run_wide;
   logic [MW-1:0]                mask_wide;

   assign idx_ok  = 32'(in_ff.task_index) < NUM_LEVELS;
   assign idx_lvl = LW'(in_ff.task_index);
   assign ticks   = TICK_BITS'(in_ff.delay_ticks);

   always_comb begin
      mask_in = mask_ff;
      wait_in = wait_ff;
      unique case (in_ff.action)
         ACT_CREATE: begin
            if (idx_ok) begin
               mask_in[idx_lvl] = 1'b1;
               wait_in[idx_lvl] = '0;
            end
         end
         ACT_POST: begin
            if (idx_ok) mask_in[idx_lvl] = 1'b1;
         end
         ACT_SUSPEND: begin
            mask_in[run_ff] = 1'b0;
         end
         ACT_DELAY: begin
            mask_in[run_ff] = 1'b0;
            wait_in[run_ff] = ticks;
         end
         ACT_TICK: begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
               if (wait_ff[i] != '0) begin
                  wait_in[i] = wait_ff[i] - 1'b1;
                  if (wait_ff[i] == TICK_BITS'(1)) mask_in[i] = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // Lowest-numbered ready level wins; the idle level runs when none is ready.
   always_comb begin
      run_in = IDLE_LEVEL;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (mask_in[i]) run_in = LW'(i);
      end
   end

   assign run_wide  = PW'(run_in);
   assign mask_wide = MW'(mask_in);

   always_comb begin
      rsp_in.task_now   = run_wide[2:0];
      rsp_in.switched   = run_in != run_ff;
      rsp_in.ready_bits = mask_wide[7:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) in_ff <= req_data;
      if (cmd.execute) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= IDLE_MASK;
         run_ff  <= IDLE_LEVEL;
         for (int i = 0; i < NUM_LEVELS; i++) wait_ff[i] <= '0;
      end else if (cmd.execute) begin
         mask_ff <= mask_in;
         run_ff  <= run_in;
         wait_ff <= wait_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> hw/rtl/priority_ready_table_scheduler.sv
// Top level of the priority ready table scheduler: controller plus datapath.
// The request beat is captured in the idle state, the execute state loads the
// result register, and the result beat is offered from the edge that ends it.
// No request is taken in the execute state, so one request executes before the next is taken.
// A request is taken while the previous result waits only if that result drains.
// Reset is synchronous and active high: only the idle level is ready, the idle
// level runs, and all wait counters are zero.
`default_nettype none

module priority_ready_table_scheduler
   import prts_pkg::*;
#(
   parameter int NUM_LEVELS = 8,
   parameter int TICK_BITS  = 16
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire prts_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output prts_rsp_type      rsp_data
);

   // Commands from the controller to the datapath: capture latches the request
   // beat, execute applies the action and loads the result register.
   prts_cmd_type cmd;

   prts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath holds the ready bitmap, the running level and one wait
   // counter per level. All nonzero counters decrement side by side on a tick, and a
   // priority encoder picks the next running level in the execute cycle.
   prts_dpath #(
      .NUM_LEVELS (NUM_LEVELS),
      .TICK_BITS  (TICK_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   // While one request is being executed no second one may be taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted during execute");

   // Every accepted request yields a result beat once the execute state has loaded it.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##2 rsp_valid)
      else $error("result beat missing after request");

   // Execute only ever follows a capture in the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> $past(cmd.capture))
      else $error("execute without captured request");
`endif

endmodule

`default_nettype wire

>>> sim/tb_priority_ready_table_scheduler.sv
// Self-checking testbench for the priority ready table scheduler.
`default_nettype none

module tb_priority_ready_table_scheduler;
   import prts_pkg::*;

   localparam int         LEVEL_COUNT  = 8;
   localparam logic [2:0] IDLE_LEVEL   = 3'd7;
   localparam int         IDLE_LIMIT   = 3000;
   localparam int         HOLD_CYCLES  = 80;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         PRINT_CAP    = 100;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   prts_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   prts_rsp_type rsp_data;

   priority_ready_table_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mirror of the scheduler state, updated once per accepted request beat.
   logic [LEVEL_COUNT-1:0] model_ready   = 8'h80;
   logic [2:0]             model_running = IDLE_LEVEL;
   logic [15:0]            model_wait [LEVEL_COUNT];

   prts_rsp_type schedule_q [$];
   prts_rsp_type want;

   int  error_count     = 0;
   int  items_sent      = 0;
   int  results_checked = 0;
   bit  gap_enable      = 1'b0;
   logic stall_enable   = 1'b0;

   // Receiver-side controls: a long hold-off is requested by bumping hold_req_count.
   int hold_req_count  = 0;
   int hold_seen_count = 0;
   int hold_left       = 0;
   int stall_left      = 0;
   int idle_cycles     = 0;

   initial begin
      for (int i = 0; i < LEVEL_COUNT; i++) model_wait[i] = '0;
   end

   // Applies one action to the mirrored state and returns the result it should produce.
   function automatic prts_rsp_type apply_action(prts_req_type r);
      logic [2:0]   prev;
      prts_rsp_type o;
      prev = model_running;
      case (r.action)
         ACT_CREATE: begin
            model_ready[r.task_index] = 1'b1;
            model_wait[r.task_index]  = '0;
         end
         ACT_POST:    model_ready[r.task_index] = 1'b1;
         ACT_SUSPEND: model_ready[model_running] = 1'b0;
         ACT_DELAY: begin
            model_ready[model_running] = 1'b0;
            model_wait[model_running]  = r.delay_ticks;
         end
         ACT_TICK: begin
            for (int i = 0; i < LEVEL_COUNT; i++) begin
               if (model_wait[i] != '0) begin
                  model_wait[i] = model_wait[i] - 16'd1;
                  if (model_wait[i] == '0) model_ready[i] = 1'b1;
               end
            end
         end
         default: ;
      endcase
      // The lowest-numbered ready level wins; with nothing ready the idle level runs.
      model_running = IDLE_LEVEL;
      for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
         if (model_ready[i]) model_running = 3'(i);
      end
      o.task_now   = model_running;
      o.switched   = (model_running != prev);
      o.ready_bits = model_ready;
      return o;
   endfunction

   task automatic report_mismatch(string what, int exp_v, int got_v);
      error_count++;
      // Printing stops after PRINT_CAP mismatches so a badly broken block does not flood the log.
      if (error_count <= PRINT_CAP)
         $display("MISMATCH at result %0d: %s expected %0d got %0d",
                  results_checked, what, exp_v, got_v);
   endtask

   // Checks every result beat against the oldest prediction, then records a new
   // prediction for any request beat accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (schedule_q.size() == 0) begin
               report_mismatch("unexpected result beat", 0, int'(rsp_data));
            end else begin
               want = schedule_q.pop_front();
               if (rsp_data.task_now != want.task_now)
                  report_mismatch("task_now", int'(want.task_now),
                                  int'(rsp_data.task_now));
               if (rsp_data.switched != want.switched)
                  report_mismatch("switched", int'(want.switched),
                                  int'(rsp_data.switched));
               if (rsp_data.ready_bits != want.ready_bits)
                  report_mismatch("ready_bits", int'(want.ready_bits),
                                  int'(rsp_data.ready_bits));
               results_checked++;
            end
         end
         if (req_valid && !req_stall) schedule_q.push_back(apply_action(req_data));
      end
   end

   // Receiver stall pattern: mostly free, short bursts, an occasional long one,
   // and a long hold-off whenever a test asks for it.
   always @(posedge clock) begin
      int r;
      if (hold_req_count != hold_seen_count) begin
         hold_seen_count = hold_req_count;
         hold_left       = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!stall_enable) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_stall <= 1'b0;
         end else if (r < 94) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            stall_left = $urandom_range(10, 30);
            rsp_stall <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      if (!gap_enable) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // Offers one request beat and returns at the edge where it is accepted.
   task automatic send_request(logic [2:0] act, logic [2:0] idx, logic [15:0] ticks);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{action: act, task_index: idx, delay_ticks: ticks};
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic test_unknown_actions();
      // Codes above tick must leave the state alone and never switch.
      send_request(3'd5, 3'd0, 16'h0000);
      send_request(3'd6, 3'd7, 16'hFFFF);
      send_request(3'd7, 3'd3, 16'h5A5A);
   endtask

   task automatic test_create_post();
      send_request(ACT_CREATE, 3'd3, 16'hFFFF);
      send_request(ACT_CREATE, 3'd0, 16'h0000);
      send_request(ACT_CREATE, 3'd7, 16'h0001);
      send_request(ACT_POST,   3'd5, 16'h8000);
   endtask

   task automatic test_suspend();
      // Walks down the ready levels, then suspends the idle level itself so the
      // bitmap empties while the idle level keeps running.
      repeat (4) send_request(ACT_SUSPEND, 3'd0, 16'h0000);
   endtask

   task automatic test_delay_and_tick();
      send_request(ACT_CREATE, 3'd2, 16'h0000);
      // A zero delay parks the level until it is posted again.
      send_request(ACT_DELAY,  3'd0, 16'h0000);
      send_request(ACT_TICK,   3'd0, 16'h0000);
      send_request(ACT_POST,   3'd2, 16'h0000);
      send_request(ACT_DELAY,  3'd0, 16'd3);
      repeat (3) send_request(ACT_TICK, 3'd0, 16'h0000);
      // Posting while the counter still runs: the later expiry sets the bit again.
      send_request(ACT_DELAY,  3'd0, 16'd2);
      send_request(ACT_POST,   3'd2, 16'h0000);
      repeat (2) send_request(ACT_TICK, 3'd0, 16'h0000);
      // Longest delay on the most urgent level but one.
      send_request(ACT_CREATE, 3'd1, 16'h0000);
      send_request(ACT_DELAY,  3'd0, 16'hFFFF);
   endtask

   task automatic test_random_actions(int count);
      int          r;
      logic [2:0]  act;
      logic [15:0] ticks;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 20)      act = ACT_CREATE;
         else if (r < 35) act = ACT_POST;
         else if (r < 45) act = ACT_SUSPEND;
         else if (r < 65) act = ACT_DELAY;
         else if (r < 95) act = ACT_TICK;
         else             act = 3'($urandom_range(5, 7));
         // Delays are mostly short so that counters actually expire under ticks.
         r = $urandom_range(0, 99);
         if (r < 50)      ticks = 16'($urandom_range(0, 6));
         else if (r < 85) ticks = 16'($urandom_range(7, 40));
         else             ticks = 16'($urandom_range(0, 65535));
         send_request(act, 3'($urandom_range(0, 7)), ticks);
      end
   endtask

   task automatic test_backpressure();
      // The receiver holds off for a long stretch while requests keep coming,
      // so the block fills up and must stall its request channel.
      gap_enable = 1'b0;
      hold_req_count <= hold_req_count + 1;
      test_random_actions(20);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_unknown_actions();
      test_create_post();
      test_suspend();
      test_delay_and_tick();

      gap_enable = 1'b1;
      stall_enable <= 1'b1;
      test_random_actions(200);

      // A stretch at full rate with no idling on either side.
      gap_enable = 1'b0;
      stall_enable <= 1'b0;
      test_random_actions(100);

      test_backpressure();

      gap_enable = 1'b1;
      stall_enable <= 1'b1;
      test_random_actions(150);

      req_valid <= 1'b0;
      while (results_checked < items_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats (directed and random actions, gaps, stalls,",
               items_sent);
      $display("a long receiver hold-off); checked %0d result beats, %0d mismatches.",
               results_checked, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

`default_nettype wire
